[hdl/nearest_target_window_filter_top_assert.svh]
// Assertion macros for the nearest target window filter checker.
`ifndef NEAREST_TARGET_WINDOW_FILTER_TOP_ASSERT_SVH
`define NEAREST_TARGET_WINDOW_FILTER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NTW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ntw_pkg.sv]
// Shared types and constants of the nearest target window filter.
`timescale 1ns / 1ps

package ntw_pkg;

    localparam int FIELD_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int LIMIT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES = 2'd2;

    localparam logic [FIELD_W-1:0] MAX_DIST_RST      = 16'd2500;
    localparam logic [LIMIT_W-1:0] EMPTY_LIMIT_RST   = 5'd9;
    localparam logic [LIMIT_W-1:0] WINDOW_FRAMES_RST = 5'd10;

    typedef struct packed {
        logic signed [FIELD_W-1:0] target_x;
        logic signed [FIELD_W-1:0] target_y;
        logic                      present;
        logic                      frame_end;
    } target_word_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic        [FIELD_W-1:0] out_dist;
        logic                      found;
    } point_word_t;

endpackage

[hdl/ntw_stream_if.sv]
// Valid/ready stream channel carrying one word per handshake.
`timescale 1ns / 1ps

interface ntw_stream_if #(parameter type word_t = logic);

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[hdl/nearest_target_window_filter_top.sv]
// Nearest target window filter: per-frame nearest target, window of frames, output pick.
//
//   channel  dir  word                     handshake
//   target   in   ntw_pkg::target_word_t   valid/ready
//   point    out  ntw_pkg::point_word_t    valid/ready
//   cfg      in   index + 16-bit data      cfg_we, no back-pressure
//
// A word with a target is accepted, then makes three passes through the one 16x16
// squarer (x squared, y squared, limit squared). A frame end adds a bit-by-bit square
// root on the same squarer and a window write; once window_frames frames (clamped
// to 2..17) are seen, it walks window_frames - 1 entries (one registered memory read
// per cycle) and then loads the output.
// Reset clears control state and the per-entry valid bits; no clearing pass is needed.
// A result waiting on point does not block target; only a second result waits for it.
`timescale 1ns / 1ps

module nearest_target_window_filter_top #(
    parameter int MAX_WINDOW = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ntw_stream_if.sink                      target,
    ntw_stream_if.source                    point,
    input  logic                            cfg_we,
    input  logic [ntw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ntw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int FW     = ntw_pkg::FIELD_W;
    localparam int LW     = ntw_pkg::LIMIT_W;
    localparam int EXT_W  = (COORD_BITS > FW ? COORD_BITS : FW) + 1;
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int FS_W   = $clog2(MAX_WINDOW + 2);
    localparam int WF_W   = FS_W > LW ? FS_W : LW;
    localparam int SQ_W   = 2 * FW;
    localparam int BIT_W  = $clog2(FW);

    localparam logic signed [EXT_W-1:0] C_HI = EXT_W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [EXT_W-1:0] C_LO = ~C_HI;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQX  = 7'b0000010,
        S_SQY  = 7'b0000100,
        S_LIM  = 7'b0001000,
        S_ROOT = 7'b0010000,
        S_FEND = 7'b0100000,
        S_SCAN = 7'b1000000
    } state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic        [FW-1:0]         d;
    } entry_t;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [FW-1:0] v
    );
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e > C_HI)
            e = C_HI;
        else if (e < C_LO)
            e = C_LO;
        return e[COORD_BITS-1:0];
    endfunction

    function automatic logic [FW-1:0] mag(input logic signed [COORD_BITS-1:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e < 0)
            e = -e;
        return e[FW-1:0];
    endfunction

    function automatic logic signed [FW-1:0] to_field(input logic signed [COORD_BITS-1:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[FW-1:0];
    endfunction

    state_t state_reg, state_next;

    // configuration
    logic [FW-1:0] max_dist_reg;
    logic [LW-1:0] empty_limit_reg;
    logic [LW-1:0] window_frames_reg;

    // current item
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [FW-1:0]                ax_reg, ay_reg;
    logic                         fend_reg;
    logic [SQ_W-1:0]              acc_reg;

    // frame best
    logic signed [COORD_BITS-1:0] best_x_reg, best_y_reg;
    logic [SQ_W-1:0]              best_sq_reg;
    logic                         has_reg;

    // square root
    logic [FW-1:0]    root_reg;
    logic [BIT_W-1:0] bit_reg;

    // window
    entry_t                 win_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  win_valid_reg;
    logic [IDX_W-1:0]       head_reg;
    logic [FS_W-1:0]        frames_seen_reg;
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic                   rd_pend_reg;
    logic [IDX_W-1:0]       scan_addr_reg;
    logic [CNT_W-1:0]       issue_left_reg;
    logic [CNT_W-1:0]       empties_reg;
    logic                   hit_reg;
    entry_t                 hit_reg_entry;

    // output
    logic                   out_valid_reg;
    ntw_pkg::point_word_t   out_word_reg;

    // shared squarer
    logic [FW-1:0]   mul_a, mul_b;
    logic [SQ_W-1:0] prod;
    logic [FW-1:0]   root_try;

    logic                  accept;
    logic                  mem_we;
    entry_t                new_entry;
    logic [WF_W-1:0]       wf_raw, wf;
    logic [CNT_W-1:0]      scan_len;
    logic [FS_W-1:0]       frames_seen_next;
    logic                  emit_go;
    logic                  scan_done;
    logic                  rd_nonempty;
    logic                  out_free;
    logic                  take_best;

    assign accept       = target.valid && target.ready;
    assign target.ready = (state_reg == S_IDLE);
    assign point.valid  = out_valid_reg;
    assign point.data   = out_word_reg;
    assign out_free     = !out_valid_reg || point.ready;

    assign root_try = root_reg | (FW'(1) << bit_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg) inside
            S_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_LIM:
            begin
                mul_a = max_dist_reg;
                mul_b = max_dist_reg;
            end
            S_ROOT:
            begin
                mul_a = root_try;
                mul_b = root_try;
            end
            S_IDLE, S_FEND, S_SCAN:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign take_best = (acc_reg <= prod) && (!has_reg || acc_reg < best_sq_reg);

    // window length from the live register, clamped to the supported range
    always_comb
    begin
        wf_raw = WF_W'(window_frames_reg);
        if (wf_raw < WF_W'(2))
            wf = WF_W'(2);
        else if (wf_raw > WF_W'(MAX_WINDOW + 1))
            wf = WF_W'(MAX_WINDOW + 1);
        else
            wf = wf_raw;
        scan_len = CNT_W'(wf - WF_W'(1));
    end

    assign frames_seen_next = (frames_seen_reg < FS_W'(MAX_WINDOW + 1))
                            ? frames_seen_reg + FS_W'(1) : frames_seen_reg;
    assign emit_go = WF_W'(frames_seen_next) >= wf;

    assign mem_we      = (state_reg == S_FEND);
    assign new_entry   = '{x: best_x_reg, y: best_y_reg, d: root_reg};
    assign rd_nonempty = rd_valid_reg && (rd_data_reg.d != '0);
    assign scan_done   = (issue_left_reg == '0) && !rd_pend_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (target.data.present)
                        state_next = S_SQX;
                    else if (target.data.frame_end)
                        state_next = S_ROOT;
                end
            end
            S_SQX:
                state_next = S_SQY;
            S_SQY:
                state_next = S_LIM;
            S_LIM:
                state_next = fend_reg ? S_ROOT : S_IDLE;
            S_ROOT:
            begin
                if (bit_reg == '0)
                    state_next = S_FEND;
            end
            S_FEND:
                state_next = emit_go ? S_SCAN : S_IDLE;
            S_SCAN:
            begin
                if (scan_done && out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            max_dist_reg      <= ntw_pkg::MAX_DIST_RST;
            empty_limit_reg   <= ntw_pkg::EMPTY_LIMIT_RST;
            window_frames_reg <= ntw_pkg::WINDOW_FRAMES_RST;
            best_x_reg        <= '0;
            best_y_reg        <= '0;
            best_sq_reg       <= '0;
            has_reg           <= 1'b0;
            win_valid_reg     <= '0;
            head_reg          <= '0;
            frames_seen_reg   <= '0;
            rd_pend_reg       <= 1'b0;
            issue_left_reg    <= '0;
            empties_reg       <= '0;
            hit_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    ntw_pkg::REG_MAX_DIST:      max_dist_reg      <= cfg_data[FW-1:0];
                    ntw_pkg::REG_EMPTY_LIMIT:   empty_limit_reg   <= cfg_data[LW-1:0];
                    ntw_pkg::REG_WINDOW_FRAMES: window_frames_reg <= cfg_data[LW-1:0];
                    default:                    ;
                endcase
            end

            if (state_reg == S_LIM && take_best)
            begin
                best_x_reg  <= x_reg;
                best_y_reg  <= y_reg;
                best_sq_reg <= acc_reg;
                has_reg     <= 1'b1;
            end

            if (state_reg == S_FEND)
            begin
                win_valid_reg[head_reg] <= 1'b1;
                head_reg        <= (head_reg == IDX_W'(MAX_WINDOW - 1))
                                 ? '0 : head_reg + IDX_W'(1);
                frames_seen_reg <= frames_seen_next;
                best_x_reg      <= '0;
                best_y_reg      <= '0;
                best_sq_reg     <= '0;
                has_reg         <= 1'b0;
                issue_left_reg  <= scan_len;
                rd_pend_reg     <= 1'b0;
                empties_reg     <= '0;
                hit_reg         <= 1'b0;
            end

            if (state_reg == S_SCAN)
            begin
                rd_pend_reg <= (issue_left_reg != '0);
                if (issue_left_reg != '0)
                    issue_left_reg <= issue_left_reg - CNT_W'(1);
                if (rd_pend_reg)
                begin
                    if (!rd_nonempty)
                        empties_reg <= empties_reg + CNT_W'(1);
                    else if (!hit_reg)
                        hit_reg <= 1'b1;
                end
            end

            // load the next result at the end of a walk, else drop the word once taken
            if (state_reg == S_SCAN && scan_done && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && point.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sat_coord(target.data.target_x);
            y_reg    <= sat_coord(target.data.target_y);
            ax_reg   <= mag(sat_coord(target.data.target_x));
            ay_reg   <= mag(sat_coord(target.data.target_y));
            fend_reg <= target.data.frame_end;
            root_reg <= '0;
            bit_reg  <= BIT_W'(FW - 1);
        end

        if (state_reg == S_SQX)
            acc_reg <= prod;
        else if (state_reg == S_SQY)
            acc_reg <= acc_reg + prod;

        if (state_reg == S_LIM)
        begin
            root_reg <= '0;
            bit_reg  <= BIT_W'(FW - 1);
        end

        if (state_reg == S_ROOT)
        begin
            if (prod <= best_sq_reg)
                root_reg <= root_try;
            if (bit_reg != '0)
                bit_reg <= bit_reg - BIT_W'(1);
        end

        if (state_reg == S_FEND)
            scan_addr_reg <= head_reg;
        else if (state_reg == S_SCAN && issue_left_reg != '0)
            scan_addr_reg <= (scan_addr_reg == '0)
                           ? IDX_W'(MAX_WINDOW - 1) : scan_addr_reg - IDX_W'(1);

        if (state_reg == S_SCAN && rd_pend_reg && rd_nonempty && !hit_reg)
            hit_reg_entry <= rd_data_reg;

        if (state_reg == S_SCAN && scan_done && out_free)
        begin
            if (hit_reg && (WF_W'(empties_reg) <= WF_W'(empty_limit_reg)))
            begin
                out_word_reg.out_x    <= to_field(hit_reg_entry.x);
                out_word_reg.out_y    <= to_field(hit_reg_entry.y);
                out_word_reg.out_dist <= hit_reg_entry.d;
                out_word_reg.found    <= 1'b1;
            end
            else
            begin
                out_word_reg.out_x    <= '0;
                out_word_reg.out_y    <= '0;
                out_word_reg.out_dist <= '0;
                out_word_reg.found    <= 1'b0;
            end
        end
    end

    // window memory: one write port at the head, one registered read port for the walk
    always_ff @(posedge clk)
    begin
        if (mem_we)
            win_mem[head_reg] <= new_entry;
        rd_data_reg  <= win_mem[scan_addr_reg];
        rd_valid_reg <= win_valid_reg[scan_addr_reg];
    end

endmodule

[hdl/ntw_checker.sv]
// Port-level checker for the nearest target window filter, bound to the top level.
`timescale 1ns / 1ps
`include "nearest_target_window_filter_top_assert.svh"

module ntw_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       target_valid,
    input logic                       target_ready,
    input logic                       target_present,
    input logic                       point_valid,
    input logic                       point_ready,
    input logic [ntw_pkg::FIELD_W-1:0] out_x,
    input logic [ntw_pkg::FIELD_W-1:0] out_y,
    input logic [ntw_pkg::FIELD_W-1:0] out_dist,
    input logic                       found
);

    `NTW_ASSERT_NEXT(a_point_held, point_valid && !point_ready, point_valid, "point word dropped while stalled")
    `NTW_ASSERT_SAME(a_zero_point, point_valid && !found, out_x == '0 && out_y == '0 && out_dist == '0, "empty result carries nonzero fields")
    `NTW_ASSERT_SAME(a_found_dist, point_valid && found, out_dist != '0, "found result with zero distance")
    `NTW_ASSERT_NEXT(a_busy_after_target, target_valid && target_ready && target_present, !target_ready, "ready while squaring a target")

endmodule

bind nearest_target_window_filter_top ntw_checker u_ntw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .target_valid   (target.valid),
    .target_ready   (target.ready),
    .target_present (target.data.present),
    .point_valid    (point.valid),
    .point_ready    (point.ready),
    .out_x          (point.data.out_x),
    .out_y          (point.data.out_y),
    .out_dist       (point.data.out_dist),
    .found          (point.data.found)
);
